// File: hw/rtl/round_robin_task_scheduler_with_delay_assert.svh
// Assertion macros used by the scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_WITH_DELAY_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_WITH_DELAY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rrts_pkg.sv
// Types and constants shared by the scheduler RTL.
package rrts_pkg;

  localparam int TICK_W     = 32;
  localparam int MODE_W     = 2;
  localparam int RUN_TASK_W = 3;
  localparam int MASK_W     = 5;

  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [TICK_W-1:0]     tick_t;
  typedef logic [RUN_TASK_W-1:0] run_task_t;
  typedef logic [MASK_W-1:0]     mask_t;

  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_DELAY = 2'd1;
  localparam mode_t MODE_PICK  = 2'd2;

  // Control broadcast from the sequencer to every task cell.
  typedef struct packed {
    logic  tick_en;
    logic  delay_en;
    tick_t tick_val;
    tick_t wake_val;
    logic  token_load;
    logic  token_shift;
  } cell_ctl_t;

endpackage

// File: hw/rtl/rrts_in_if.sv
// Input channel: one scheduler event per transaction.
interface rrts_in_if;
  import rrts_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  tick_t delay_ticks;

  modport source (output valid, output mode, output delay_ticks, input ready);
  modport sink   (input valid, input mode, input delay_ticks, output ready);
endinterface

// File: hw/rtl/rrts_out_if.sv
// Result channel: scheduler status after each event.
interface rrts_out_if;
  import rrts_pkg::*;

  logic      valid;
  logic      ready;
  run_task_t running_task;
  logic      switch_request;
  logic      delay_ignored;
  tick_t     tick_now;
  mask_t     ready_mask;

  modport source (output valid, output running_task, output switch_request,
                  output delay_ignored, output tick_now, output ready_mask, input ready);
  modport sink   (input valid, input running_task, input switch_request,
                  input delay_ignored, input tick_now, input ready_mask, output ready);
endinterface

// File: hw/rtl/round_robin_task_scheduler_with_delay.sv
// A tick or delay event passes through the execute and done states before its result is
// registered; a pick also runs the token search, which walks the cell ring one cell per cycle.
// One event is in work at a time: the next is taken only once the sequencer is idle again
// and the result register is empty or being drained.
// Reset (synchronous, rst_n low): tick count 0, task 1 running, every task ready.
// Wake ticks are not reset; they are written whenever a task blocks.
`include "round_robin_task_scheduler_with_delay_assert.svh"

module round_robin_task_scheduler_with_delay #(
  parameter int NUM_TASKS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  rrts_in_if.sink     in_chan,
  rrts_out_if.source  out_chan
);
  import rrts_pkg::*;

  localparam int IDX_W = $clog2(NUM_TASKS);

  // Sequencer state codes.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  mode_t            mode_r;
  tick_t            delay_r;
  tick_t            tick_r, tick_nxt;
  logic [IDX_W-1:0] running_r, running_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic             sw_r, sw_nxt;
  logic             ign_r, ign_nxt;

  logic             out_valid_r, out_valid_nxt;
  run_task_t        out_task_r;
  logic             out_sw_r;
  logic             out_ign_r;
  tick_t            out_tick_r;
  mask_t            out_mask_r;

  logic                 accept;
  logic                 run_busy;
  tick_t                tick_inc;
  tick_t                wake_sum;
  logic [IDX_W-1:0]     start_idx;
  cell_ctl_t            ctl;
  logic [NUM_TASKS-1:0] sel_vec;
  logic [NUM_TASKS-1:0] token_init_vec;
  logic [NUM_TASKS-1:0] token_vec;
  logic [NUM_TASKS-1:0] ready_vec;
  logic [NUM_TASKS-1:0] cand;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;

  // A new event is taken only when the sequencer is idle and the result register
  // is empty or being drained in this very cycle, so a result never overwrites one.
  assign in_chan.ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;

  // The idle task (slot 0) is never blocked: a delay only hits a non-idle task.
  assign run_busy = (running_r != '0);
  assign tick_inc = tick_r + 1'b1;
  assign wake_sum = tick_r + delay_r;

  // The round-robin search begins on the slot after the running task.
  assign start_idx = (running_r == IDX_W'(NUM_TASKS - 1)) ? '0 : running_r + 1'b1;

  always_comb begin
    ctl.tick_en     = (state_r == S_EXEC) && (mode_r == MODE_TICK);
    ctl.delay_en    = (state_r == S_EXEC) && (mode_r == MODE_DELAY) && run_busy;
    ctl.tick_val    = tick_inc;
    ctl.wake_val    = wake_sum;
    ctl.token_load  = (state_r == S_EXEC) && (mode_r == MODE_PICK);
    ctl.token_shift = (state_r == S_SCAN) && !hit;
  end

  // Row of task cells. The search token passes from each cell to the next and
  // wraps from the last cell back to the idle slot.
  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    assign sel_vec[g]        = (running_r == IDX_W'(g));
    assign token_init_vec[g] = (start_idx == IDX_W'(g));

    rrts_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .sel        (sel_vec[g]),
      .token_init (token_init_vec[g]),
      .token_prev (token_vec[(g + NUM_TASKS - 1) % NUM_TASKS]),
      .ready      (ready_vec[g]),
      .token      (token_vec[g])
    );
  end

  // The cell holding the token claims the CPU if its task is ready and not idle.
  always_comb begin
    cand    = token_vec & ready_vec & ~NUM_TASKS'(1);
    hit     = |cand;
    hit_idx = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (cand[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  // Sequencer: execute the event, run the token search for a pick, then
  // load the result register from the updated state.
  always_comb begin
    state_nxt   = state_r;
    tick_nxt    = tick_r;
    running_nxt = running_r;
    step_nxt    = step_r;
    sw_nxt      = sw_r;
    ign_nxt     = ign_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        sw_nxt    = 1'b0;
        ign_nxt   = 1'b0;
        state_nxt = S_DONE;
        case (mode_r)
          MODE_TICK: begin
            tick_nxt = tick_inc;
            sw_nxt   = 1'b1;
          end
          MODE_DELAY: begin
            sw_nxt  = run_busy;
            ign_nxt = !run_busy;
          end
          MODE_PICK: begin
            step_nxt  = '0;
            state_nxt = S_SCAN;
          end
          default: begin
            // The unused code leaves the state alone; its result shows no switch and no ignored delay.
          end
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          running_nxt = hit_idx;
          state_nxt   = S_DONE;
        end else if (step_r == IDX_W'(NUM_TASKS - 1)) begin
          // Every slot visited, the running task last: fall back to idle.
          running_nxt = '0;
          state_nxt   = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_DONE) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      running_r   <= IDX_W'(1);
      step_r      <= '0;
      sw_r        <= 1'b0;
      ign_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      running_r   <= running_nxt;
      step_r      <= step_nxt;
      sw_r        <= sw_nxt;
      ign_r       <= ign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event payload and result payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_chan.mode;
      delay_r <= in_chan.delay_ticks;
    end
    if (state_r == S_DONE) begin
      out_task_r <= RUN_TASK_W'(running_r);
      out_sw_r   <= sw_r;
      out_ign_r  <= ign_r;
      out_tick_r <= tick_r;
      out_mask_r <= MASK_W'(ready_vec);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.running_task   = out_task_r;
  assign out_chan.switch_request = out_sw_r;
  assign out_chan.delay_ignored  = out_ign_r;
  assign out_chan.tick_now       = out_tick_r;
  assign out_chan.ready_mask     = out_mask_r;

  `RRTS_ASSERT_NOW(a_token_single, 1'b1, $onehot0(token_vec), "more than one search token")
  `RRTS_ASSERT_NOW(a_scan_token, state_r == S_SCAN, $onehot(token_vec), "search lost its token")
  `RRTS_ASSERT_NOW(a_idle_ready, 1'b1, ready_vec[0], "idle task became blocked")
  `RRTS_ASSERT_NOW(a_run_range, 1'b1, running_r <= IDX_W'(NUM_TASKS - 1), "running task out of range")
  `RRTS_ASSERT_NEXT(a_accept_exec, accept, state_r == S_EXEC, "accepted event not executed")
  `RRTS_ASSERT_NOW(a_done_free, state_r == S_DONE, !out_valid_r, "result register still occupied")

endmodule

// File: hw/rtl/rrts_cell.sv
// One task slot: ready flag, wake tick and the round-robin search token.
module rrts_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rrts_pkg::cell_ctl_t ctl,
  input  logic              sel,
  input  logic              token_init,
  input  logic              token_prev,
  output logic              ready,
  output logic              token
);
  import rrts_pkg::*;

  logic  ready_r, ready_nxt;
  logic  token_r, token_nxt;
  tick_t wake_r;

  always_comb begin
    ready_nxt = ready_r;
    if (ctl.delay_en && sel) begin
      ready_nxt = 1'b0;
    end else if (ctl.tick_en && !ready_r && (wake_r == ctl.tick_val)) begin
      ready_nxt = 1'b1;
    end
  end

  always_comb begin
    token_nxt = token_r;
    if (ctl.token_load) begin
      token_nxt = token_init;
    end else if (ctl.token_shift) begin
      token_nxt = token_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b1;
      token_r <= 1'b0;
    end else begin
      ready_r <= ready_nxt;
      token_r <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.delay_en && sel) begin
      wake_r <= ctl.wake_val;
    end
  end

  assign ready = ready_r;
  assign token = token_r;

endmodule
